// ===== design/bmhq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmhq_pkg
// shared types and constants of the binary min-heap queue
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int KEY_W        = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_OUT_W  = 11;
    localparam int CAPACITY_DEF = 1024;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_UP_LAST,
        ST_POP_LOAD,
        ST_DOWN,
        ST_RESULT
    } state_t;

endpackage

// ===== design/bmhq_cmd_if.sv =====
// ----------------------------------------------------------------------------
// bmhq_cmd_if
// command channel: push of a key or pop of the minimum
// ----------------------------------------------------------------------------
interface bmhq_cmd_if;
    import bmhq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    cmd;
    logic signed [KEY_W-1:0] key_in;

    modport source (output valid, output cmd, output key_in, input ready);
    modport sink   (input valid, input cmd, input key_in, output ready);
endinterface

// ===== design/bmhq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bmhq_rsp_if
// result channel: removed key, status and entry count
// ----------------------------------------------------------------------------
interface bmhq_rsp_if;
    import bmhq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [KEY_W-1:0] key_out;
    logic [STATUS_W-1:0]     status;
    logic [COUNT_OUT_W-1:0]  count_out;

    modport source (output valid, output key_out, output status, output count_out,
                    input ready);
    modport sink   (input valid, input key_out, input status, input count_out,
                    output ready);
endinterface

// ===== design/bmhq_key_ram.sv =====
// ----------------------------------------------------------------------------
// bmhq_key_ram
// key store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module bmhq_key_ram #(
    parameter int DEPTH = bmhq_pkg::CAPACITY_DEF + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                           clk,
    input  logic                           wr_en,
    input  logic [AW-1:0]                  wr_addr,
    input  logic [bmhq_pkg::KEY_W-1:0]     wr_data,
    input  logic                           rd_a_en,
    input  logic [AW-1:0]                  rd_a_addr,
    output logic [bmhq_pkg::KEY_W-1:0]     rd_a_data,
    input  logic                           rd_b_en,
    input  logic [AW-1:0]                  rd_b_addr,
    output logic [bmhq_pkg::KEY_W-1:0]     rd_b_data
);
    import bmhq_pkg::*;

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_a_data_reg;
    logic [KEY_W-1:0] rd_b_data_reg;

    // read before write on a shared address
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_a_en)
        begin
            rd_a_data_reg <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_data_reg <= mem[rd_b_addr];
        end
    end

    assign rd_a_data = rd_a_data_reg;
    assign rd_b_data = rd_b_data_reg;

endmodule

// ===== design/binary_min_heap_queue.sv =====
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// priority queue of signed 32-bit keys kept as a binary min-heap in a RAM
// ----------------------------------------------------------------------------
// Each command beat is a push of key_in or a pop of the smallest key, and
// each gives exactly one result beat with the removed key (zero unless a pop
// succeeded), a status (ok, push refused because full, pop refused because
// empty) and the entry count after the operation. Keys live in slots
// 1..CAPACITY of a RAM with one write port and two registered read ports.
// The heap walk moves one level per clock, each level a read, compare and
// write through the key RAM; a key moves at most log2 of the entry count
// levels, 10 for 1024 entries. Refused commands, a push into an empty heap
// and a pop that leaves at most one entry do no walk. One command is in work
// at a time; a finished result sits in the output register while the next
// command is taken, and a stalled result channel holds the following result
// in the work path. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module binary_min_heap_queue #(
    parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bmhq_cmd_if.sink   cmd_chan,
    bmhq_rsp_if.source rsp_chan
);
    import bmhq_pkg::*;

    // index width covers slots 0..CAPACITY and the count itself
    localparam int IW = $clog2(CAPACITY + 1);

    // control state
    state_t             state_reg, state_next;
    logic [IW-1:0]      count_reg, count_next;
    logic               out_valid_reg, out_valid_next;

    // work registers
    logic [IW-1:0]      pos_reg, pos_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [KEY_W-1:0]   res_key_reg, res_key_next;
    status_t            res_status_reg, res_status_next;

    // output register
    logic [KEY_W-1:0]       out_key_reg, out_key_next;
    status_t                out_status_reg, out_status_next;
    logic [COUNT_OUT_W-1:0] out_count_reg, out_count_next;

    // ram ports
    logic             wr_en, rd_a_en, rd_b_en;
    logic [IW-1:0]    wr_addr, rd_a_addr, rd_b_addr;
    logic [KEY_W-1:0] wr_data, rd_a_data, rd_b_data;

    bmhq_key_ram #(
        .DEPTH (CAPACITY + 1),
        .AW    (IW)
    ) u_key_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_en   (rd_a_en),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_en   (rd_b_en),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    // handshake terms
    logic cmd_fire;
    logic out_free;
    assign cmd_chan.ready = (state_reg == ST_IDLE);
    assign cmd_fire       = cmd_chan.valid && cmd_chan.ready;
    assign out_free       = !out_valid_reg || rsp_chan.ready;

    logic is_full, is_empty;
    assign is_full  = (count_reg == IW'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // push: slot of the new key
    logic [IW-1:0] push_pos;
    assign push_pos = IW'(count_reg + IW'(1));

    // sift up: parent comparison, parent of the parent
    logic          up_less;
    logic [IW-1:0] up_parent;
    logic [IW-1:0] up_grand;
    assign up_less   = $signed(key_reg) < $signed(rd_a_data);
    assign up_parent = pos_reg >> 1;
    assign up_grand  = pos_reg >> 2;

    // sift down: children of the hole, smaller child, left wins on a tie
    logic [IW:0]      count_ext;
    logic [IW:0]      left_idx, right_idx;
    logic             left_ok, right_ok, take_left, take_right, down_move;
    logic [KEY_W-1:0] left_best;
    logic [IW-1:0]    best_pos;
    logic [KEY_W-1:0] best_val;
    logic [IW:0]      next_left, next_right;

    assign count_ext  = {1'b0, count_reg};
    assign left_idx   = {pos_reg, 1'b0};
    assign right_idx  = left_idx + (IW+1)'(1);
    assign left_ok    = left_idx <= count_ext;
    assign right_ok   = right_idx <= count_ext;
    assign take_left  = left_ok && ($signed(rd_a_data) < $signed(key_reg));
    assign left_best  = take_left ? rd_a_data : key_reg;
    assign take_right = right_ok && ($signed(rd_b_data) < $signed(left_best));
    assign down_move  = take_left || take_right;
    assign best_pos   = take_right ? right_idx[IW-1:0] : left_idx[IW-1:0];
    assign best_val   = take_right ? rd_b_data : rd_a_data;
    assign next_left  = {best_pos, 1'b0};
    assign next_right = next_left + (IW+1)'(1);

    // first level below the root after a pop, against the reduced count
    logic [IW:0] pop_count_ext;
    assign pop_count_ext = {1'b0, IW'(count_reg - IW'(1))};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd_chan.cmd == CMD_PUSH)
                    begin
                        state_next = (is_full || is_empty) ? ST_RESULT : ST_UP;
                    end
                    else
                    begin
                        state_next = is_empty ? ST_RESULT : ST_POP_LOAD;
                    end
                end
            end
            ST_UP:
            begin
                if (!up_less)
                begin
                    state_next = ST_RESULT;
                end
                else if (up_parent == IW'(1))
                begin
                    state_next = ST_UP_LAST;
                end
            end
            ST_UP_LAST:
            begin
                state_next = ST_RESULT;
            end
            ST_POP_LOAD:
            begin
                state_next = (count_reg <= IW'(2)) ? ST_RESULT : ST_DOWN;
            end
            ST_DOWN:
            begin
                if (!down_move)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        out_key_next    = out_key_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_valid_next  = out_valid_reg && !rsp_chan.ready;
        wr_en           = 1'b0;
        wr_addr         = pos_reg;
        wr_data         = key_reg;
        rd_a_en         = 1'b0;
        rd_a_addr       = up_grand;
        rd_b_en         = 1'b0;
        rd_b_addr       = next_right[IW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    res_key_next    = '0;
                    res_status_next = STAT_OK;
                    key_next        = cmd_chan.key_in;
                    if (cmd_chan.cmd == CMD_PUSH)
                    begin
                        if (is_full)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            count_next = push_pos;
                            pos_next   = push_pos;
                            if (is_empty)
                            begin
                                // first key goes straight to the root
                                wr_en   = 1'b1;
                                wr_addr = IW'(1);
                                wr_data = cmd_chan.key_in;
                            end
                            else
                            begin
                                rd_a_en   = 1'b1;
                                rd_a_addr = push_pos >> 1;
                            end
                        end
                    end
                    else
                    begin
                        if (is_empty)
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            // root and last entry together
                            rd_a_en   = 1'b1;
                            rd_a_addr = IW'(1);
                            rd_b_en   = 1'b1;
                            rd_b_addr = count_reg;
                        end
                    end
                end
            end
            ST_UP:
            begin
                wr_en = 1'b1;
                if (up_less)
                begin
                    // parent moves down into the hole
                    wr_data  = rd_a_data;
                    pos_next = up_parent;
                    if (up_parent != IW'(1))
                    begin
                        rd_a_en   = 1'b1;
                        rd_a_addr = up_grand;
                    end
                end
            end
            ST_UP_LAST:
            begin
                wr_en   = 1'b1;
                wr_addr = IW'(1);
            end
            ST_POP_LOAD:
            begin
                res_key_next = rd_a_data;
                count_next   = IW'(count_reg - IW'(1));
                key_next     = rd_b_data;
                pos_next     = IW'(1);
                if (count_reg == IW'(2))
                begin
                    // one entry left: last key becomes the root
                    wr_en   = 1'b1;
                    wr_addr = IW'(1);
                    wr_data = rd_b_data;
                end
                else if (count_reg > IW'(2))
                begin
                    rd_a_en   = 1'b1;
                    rd_a_addr = IW'(2);
                    rd_b_en   = (IW+1)'(3) <= pop_count_ext;
                    rd_b_addr = IW'(3);
                end
            end
            ST_DOWN:
            begin
                wr_en = 1'b1;
                if (down_move)
                begin
                    // smaller child moves up into the hole
                    wr_data   = best_val;
                    pos_next  = best_pos;
                    rd_a_en   = next_left <= count_ext;
                    rd_a_addr = next_left[IW-1:0];
                    rd_b_en   = next_right <= count_ext;
                    rd_b_addr = next_right[IW-1:0];
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_key_next    = res_key_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = COUNT_OUT_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        out_key_reg    <= out_key_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    assign rsp_chan.valid     = out_valid_reg;
    assign rsp_chan.key_out   = out_key_reg;
    assign rsp_chan.status    = out_status_reg;
    assign rsp_chan.count_out = out_count_reg;

    // the heap never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= IW'(CAPACITY))
        else $error("entry count above capacity");

    // writes land only on live slots, never on the unused slot zero
    a_write_live: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (wr_addr != '0) && (wr_addr <= count_next))
        else $error("key write outside live slots");

    // the hole is always a real slot while a sift runs
    a_hole_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UP || state_reg == ST_DOWN) |-> (pos_reg != '0))
        else $error("sift position is zero");

    // a result leaving the work path shows up on the output next cycle
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_free) |=> rsp_chan.valid)
        else $error("result not presented");

    // a pop in work never starts from an empty heap
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP_LOAD) |-> (count_reg != '0))
        else $error("pop load on empty heap");

endmodule
